// ===== hw/rtl/lec3_pkg.sv =====
// Shared constants and types for the 3x3 local extremum counter.
`timescale 1ns / 1ps
`default_nettype none
package lec3_pkg;

   localparam int SAMPLE_W = 32;
   localparam int COUNT_W  = 32;
   localparam int ROWS_W   = 12;
   localparam int COLS_W   = 11;
   localparam int MAX_COLS = 1024;
   localparam int ADDR_W   = $clog2(MAX_COLS);
   localparam int LIM_W    = (COLS_W > ADDR_W) ? COLS_W + 1 : ADDR_W + 1;

   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_ROWS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COLS = CSR_IDX_W'(1);

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = RSP_PTR_W + 1;

   // Item held in the input register, in the cycle after the transfer.
   typedef struct packed {
      logic                       valid;
      logic                       test_en;
      logic                       last;
      logic [ADDR_W-1:0]          addr;
      logic signed [SAMPLE_W-1:0] sample;
   } s1_type;

   // Comparison outcome, registered from the item in the input register.
   typedef struct packed {
      logic valid;
      logic last;
      logic hit_max;
      logic hit_min;
   } s2_type;

   typedef struct packed {
      logic [COUNT_W-1:0] max_count;
      logic [COUNT_W-1:0] min_count;
   } rsp_type;

endpackage
`default_nettype wire

// ===== hw/rtl/lec3_if.sv =====
// Channel interfaces: sample input, count result and register write.
`timescale 1ns / 1ps
`default_nettype none
interface lec3_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface lec3_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] max_count;
   logic [31:0] min_count;

   modport source (output valid, output max_count, output min_count, input ready);
   modport sink   (input valid, input max_count, input min_count, output ready);
endinterface

interface lec3_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/lec3_line_buf.sv =====
// Two line buffers holding the previous two rows, with write-to-read bypass.
`timescale 1ns / 1ps
`default_nettype none
module lec3_line_buf (
   input  wire                             clock,
   input  wire                             rd_en,
   input  wire  [lec3_pkg::ADDR_W-1:0]     rd_addr,
   input  lec3_pkg::s1_type                s1,
   output logic [lec3_pkg::SAMPLE_W-1:0]   top_ff,
   output logic [lec3_pkg::SAMPLE_W-1:0]   mid_ff
);
   import lec3_pkg::*;

   logic [SAMPLE_W-1:0] top_mem [MAX_COLS];
   logic [SAMPLE_W-1:0] mid_mem [MAX_COLS];
   logic                bypass;

   // The item in the input register writes the address now being read when a row is one column
   assign bypass = s1.valid && (s1.addr == rd_addr);

   always_ff @(posedge clock) begin
      if (s1.valid) begin
         top_mem[s1.addr] <= mid_ff;
         mid_mem[s1.addr] <= s1.sample;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (bypass) begin
            top_ff <= mid_ff;
            mid_ff <= s1.sample;
         end else begin
            top_ff <= top_mem[rd_addr];
            mid_ff <= mid_mem[rd_addr];
         end
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/lec3_window.sv =====
// 3x3 window registers and the eight parallel strict comparisons.
`timescale 1ns / 1ps
`default_nettype none
module lec3_window (
   input  wire                            clock,
   input  wire                            reset,
   input  lec3_pkg::s1_type               s1,
   input  wire  [lec3_pkg::SAMPLE_W-1:0]  top,
   input  wire  [lec3_pkg::SAMPLE_W-1:0]  mid,
   output lec3_pkg::s2_type               s2_ff
);
   import lec3_pkg::*;

   // Column-major: 0..2 oldest column (top, mid, bottom), 6..8 newest
   logic [SAMPLE_W-1:0] window_ff [9];
   logic [SAMPLE_W-1:0] nb [8];
   logic signed [SAMPLE_W-1:0] centre;
   logic is_max;
   logic is_min;
   s2_type s2_in;

   always_comb begin
      centre = $signed(window_ff[7]);
      nb[0] = window_ff[3];
      nb[1] = window_ff[4];
      nb[2] = window_ff[5];
      nb[3] = window_ff[6];
      nb[4] = window_ff[8];
      nb[5] = top;
      nb[6] = mid;
      nb[7] = s1.sample;
      is_max = 1'b1;
      is_min = 1'b1;
      for (int i = 0; i < 8; i++) begin
         if (centre <= $signed(nb[i])) is_max = 1'b0;
         if (centre >= $signed(nb[i])) is_min = 1'b0;
      end
      s2_in.valid   = s1.valid;
      s2_in.last    = s1.last;
      s2_in.hit_max = s1.valid && s1.test_en && is_max;
      s2_in.hit_min = s1.valid && s1.test_en && is_min;
   end

   always_ff @(posedge clock) begin
      if (s1.valid) begin
         for (int i = 0; i < 6; i++) window_ff[i] <= window_ff[i + 3];
         window_ff[6] <= top;
         window_ff[7] <= mid;
         window_ff[8] <= s1.sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff <= '0;
      end else begin
         s2_ff <= s2_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/lec3_rsp_fifo.sv =====
// Small result queue that decouples the counting pipeline from the consumer.
`timescale 1ns / 1ps
`default_nettype none
module lec3_rsp_fifo (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              push,
   input  lec3_pkg::rsp_type                push_data,
   input  wire                              pop,
   output lec3_pkg::rsp_type                head,
   output logic [lec3_pkg::RSP_CNT_W-1:0]   count_ff
);
   import lec3_pkg::*;

   rsp_type               entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]  wr_ptr_ff;
   logic [RSP_PTR_W-1:0]  rd_ptr_ff;

   assign head = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + RSP_PTR_W'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + RSP_PTR_W'(1);
         if (push && !pop)      count_ff <= count_ff + RSP_CNT_W'(1);
         else if (pop && !push) count_ff <= count_ff - RSP_CNT_W'(1);
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/local_extremum_counter_3x3_unit.sv =====
// Top level: frame position tracking, extremum totals and channel handshakes.
//
//   channel  | dir | transfer on         | payload
//   req_if   | in  | valid & ready       | sample (signed 32)
//   rsp_if   | out | valid & ready       | max_count, min_count (32 each)
//   csr_if   | in  | valid & ready       | index (0 rows, 1 cols), data
//
// One sample per clock unless the input stalls; results queue from the comparison register.
// The line buffers are two single-port-write memories read at the sample's column.
// Reset clears positions, totals and the result queue; line buffers are not cleared.
// The input stalls only when the four-entry result queue, counting items still in
// the pipeline, has no room left.
`timescale 1ns / 1ps
`default_nettype none
module local_extremum_counter_3x3_unit (
   input wire          clock,
   input wire          reset,
   lec3_req_if.sink    req_if,
   lec3_rsp_if.source  rsp_if,
   lec3_csr_if.sink    csr_if
);
   import lec3_pkg::*;

   logic [ROWS_W-1:0]  rows_ff;
   logic [COLS_W-1:0]  cols_ff;
   logic [ADDR_W-1:0]  col_pos_ff;
   logic [ROWS_W-1:0]  row_pos_ff;
   logic [COUNT_W-1:0] max_total_ff;
   logic [COUNT_W-1:0] min_total_ff;
   logic [COUNT_W-1:0] max_total_in;
   logic [COUNT_W-1:0] min_total_in;

   s1_type s1_ff;
   s1_type s1_in;
   s2_type s2;

   logic [ROWS_W-1:0]  rows_eff;
   logic [LIM_W-1:0]   cols_eff;
   logic [LIM_W-1:0]   col_next;
   logic [ROWS_W:0]    row_next;
   logic               end_row;
   logic               req_xfer;
   logic               rsp_xfer;
   logic               push;
   rsp_type            push_data;
   rsp_type            head;
   logic [RSP_CNT_W-1:0] fifo_count;
   logic [SAMPLE_W-1:0]  top_rd;
   logic [SAMPLE_W-1:0]  mid_rd;

   assign csr_if.ready = 1'b1;

   // Reserve a queue slot for every item still in flight
   assign req_if.ready = (RSP_CNT_W'(32'(fifo_count) + 32'(s1_ff.valid) + 32'(s2.valid))
                          < RSP_CNT_W'(RSP_DEPTH))
                         && ((32'(fifo_count) + 32'(s1_ff.valid) + 32'(s2.valid)) < RSP_DEPTH);
   assign req_xfer = req_if.valid && req_if.ready;
   assign rsp_xfer = rsp_if.valid && rsp_if.ready;

   always_comb begin
      rows_eff = (rows_ff == '0) ? ROWS_W'(1) : rows_ff;
      cols_eff = LIM_W'(cols_ff);
      if (cols_eff == '0) cols_eff = LIM_W'(1);
      if (cols_eff > LIM_W'(MAX_COLS)) cols_eff = LIM_W'(MAX_COLS);
      col_next = LIM_W'(col_pos_ff) + LIM_W'(1);
      row_next = {1'b0, row_pos_ff} + (ROWS_W + 1)'(1);
      end_row  = col_next >= cols_eff;

      s1_in.valid   = req_xfer;
      s1_in.test_en = (row_pos_ff >= ROWS_W'(2)) && (col_pos_ff >= ADDR_W'(2));
      s1_in.last    = end_row && (row_next >= {1'b0, rows_eff});
      s1_in.addr    = col_pos_ff;
      s1_in.sample  = req_if.sample;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= ROWS_W'(1);
         cols_ff <= COLS_W'(1);
      end else if (csr_if.valid) begin
         case (csr_if.index)
            CSR_FRAME_ROWS: rows_ff <= csr_if.data[ROWS_W-1:0];
            CSR_FRAME_COLS: cols_ff <= csr_if.data[COLS_W-1:0];
            default: ;
         endcase
      end
   end

   // Advance the raster position on each sample transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff <= '0;
         row_pos_ff <= '0;
      end else if (req_xfer) begin
         if (end_row) begin
            col_pos_ff <= '0;
            row_pos_ff <= s1_in.last ? '0 : row_next[ROWS_W-1:0];
         end else begin
            col_pos_ff <= col_next[ADDR_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
      end else begin
         s1_ff <= s1_in;
      end
   end

   lec3_line_buf u_line_buf (
      .clock   (clock),
      .rd_en   (req_xfer),
      .rd_addr (col_pos_ff),
      .s1      (s1_ff),
      .top_ff  (top_rd),
      .mid_ff  (mid_rd)
   );

   lec3_window u_window (
      .clock (clock),
      .reset (reset),
      .s1    (s1_ff),
      .top   (top_rd),
      .mid   (mid_rd),
      .s2_ff (s2)
   );

   // Saturating totals; drop them to zero once the frame's result is queued
   always_comb begin
      max_total_in = max_total_ff;
      min_total_in = min_total_ff;
      if (s2.hit_max && (max_total_ff != '1)) max_total_in = max_total_ff + COUNT_W'(1);
      if (s2.hit_min && (min_total_ff != '1)) min_total_in = min_total_ff + COUNT_W'(1);
      push                = s2.valid && s2.last;
      push_data.max_count = max_total_in;
      push_data.min_count = min_total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_total_ff <= '0;
         min_total_ff <= '0;
      end else if (s2.valid) begin
         max_total_ff <= s2.last ? '0 : max_total_in;
         min_total_ff <= s2.last ? '0 : min_total_in;
      end
   end

   lec3_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (rsp_xfer),
      .head      (head),
      .count_ff  (fifo_count)
   );

   assign rsp_if.valid     = fifo_count != '0;
   assign rsp_if.max_count = head.max_count;
   assign rsp_if.min_count = head.min_count;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !rsp_xfer |-> (32'(fifo_count) < RSP_DEPTH))
      else $error("result queue overflow");

   a_sample_enters: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> s1_ff.valid)
      else $error("accepted sample did not reach the input register");

   a_totals_clear: assert property (@(posedge clock) disable iff (reset)
      push |=> (max_total_ff == '0) && (min_total_ff == '0))
      else $error("totals not cleared after frame end");

   a_hit_needs_item: assert property (@(posedge clock) disable iff (reset)
      (s2.hit_max || s2.hit_min) |-> s2.valid && $past(s1_ff.valid))
      else $error("extremum flagged without an item");

endmodule
`default_nettype wire

// ===== tb/tb_local_extremum_counter_3x3_unit.sv =====
// Self-checking testbench for the 3x3 local extremum counter: frames in, counts checked.
`timescale 1ns / 1ps
module tb_local_extremum_counter_3x3_unit;
   import lec3_pkg::*;

   localparam int          SETTLE_CYCLES  = 8;
   localparam int          RANDOM_SAMPLES = 260;
   localparam int          STALL_CYCLES   = 300;
   localparam longint      RUN_LIMIT_NS   = 5_000_000;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_IDX  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_IDX = '1;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;

   typedef enum int {IDLE_NONE, IDLE_SPARSE, IDLE_FULL} idle_mode_type;
   typedef enum int {FILL_WIDE, FILL_NARROW, FILL_EXTREME} fill_type;

   logic clock = 1'b0;
   logic reset;

   lec3_req_if req_bus ();
   lec3_rsp_if rsp_bus ();
   lec3_csr_if csr_bus ();

   local_extremum_counter_3x3_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   always #2 clock = ~clock;

   // Expected behaviour of the block: line rows, window, position and totals.
   logic [SAMPLE_W-1:0]        row_older [MAX_COLS];
   logic [SAMPLE_W-1:0]        row_newer [MAX_COLS];
   logic signed [SAMPLE_W-1:0] win [9];
   int unsigned                col_at;
   int unsigned                row_at;
   logic [COUNT_W-1:0]         maxima_seen;
   logic [COUNT_W-1:0]         minima_seen;
   logic [ROWS_W-1:0]          rows_reg;
   logic [COLS_W-1:0]          cols_reg;
   rsp_type                    pending_counts [$];

   idle_mode_type source_mode = IDLE_FULL;
   idle_mode_type sink_mode   = IDLE_FULL;
   int         sink_hold_cycles = 0;
   int         error_count   = 0;
   int         samples_sent  = 0;
   int         frames_checked = 0;
   longint     maxima_total  = 0;
   longint     minima_total  = 0;

   task automatic report_mismatch(input string what);
      $display("ERROR @%0t: %s", $time, what);
      error_count++;
   endtask

   function automatic int draw_gap(input idle_mode_type mode);
      case (mode)
         IDLE_NONE:   return 0;
         IDLE_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
         default:     return $urandom_range(0, 16);
      endcase
   endfunction

   function automatic int unsigned eff_rows();
      return (rows_reg == 0) ? 1 : rows_reg;
   endfunction

   function automatic int unsigned eff_cols();
      int unsigned c;
      c = (cols_reg == 0) ? 1 : cols_reg;
      return (c > MAX_COLS) ? MAX_COLS : c;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] draw_sample(input fill_type fill);
      logic signed [SAMPLE_W-1:0] pick;
      case (fill)
         FILL_NARROW: begin
            pick = $urandom_range(0, 6);
            pick = pick - 3;
         end
         FILL_EXTREME: begin
            case ($urandom_range(0, 5))
               0:       pick = SAMPLE_MIN;
               1:       pick = SAMPLE_MAX;
               2:       pick = 0;
               3:       pick = -1;
               4:       pick = SAMPLE_MIN + 1;
               default: pick = SAMPLE_MAX - 1;
            endcase
         end
         default: pick = $urandom;
      endcase
      return pick;
   endfunction

   // Advance the expected state by one accepted sample; queue counts at frame end.
   function automatic void track_extrema(input logic signed [SAMPLE_W-1:0] value);
      int unsigned                c;
      int                         k;
      logic signed [SAMPLE_W-1:0] top;
      logic signed [SAMPLE_W-1:0] mid;
      logic                       is_max;
      logic                       is_min;
      rsp_type                    done;
      c = (col_at >= MAX_COLS) ? MAX_COLS - 1 : col_at;
      top = row_older[c];
      mid = row_newer[c];
      row_older[c] = mid;
      row_newer[c] = value;
      for (k = 0; k < 3; k++) begin
         win[k]     = win[3 + k];
         win[3 + k] = win[6 + k];
      end
      win[6] = top;
      win[7] = mid;
      win[8] = value;
      if (row_at >= 2 && c >= 2) begin
         is_max = 1'b1;
         is_min = 1'b1;
         for (k = 0; k < 9; k++) begin
            if (k != 4) begin
               if (win[4] <= win[k]) is_max = 1'b0;
               if (win[4] >= win[k]) is_min = 1'b0;
            end
         end
         if (is_max && maxima_seen != '1) maxima_seen++;
         if (is_min && minima_seen != '1) minima_seen++;
      end
      if (c + 1 >= eff_cols()) begin
         col_at = 0;
         if (row_at + 1 >= eff_rows()) begin
            done.max_count = maxima_seen;
            done.min_count = minima_seen;
            pending_counts.push_back(done);
            maxima_seen = '0;
            minima_seen = '0;
            row_at = 0;
         end else begin
            row_at = (row_at + 1) & 12'hFFF;
         end
      end else begin
         col_at = c + 1;
      end
   endfunction

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
      int gap;
      gap = draw_gap(source_mode);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.sample <= value;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      track_extrema(value);
      samples_sent++;
   endtask

   task automatic send_frame(input fill_type fill);
      int unsigned n;
      n = eff_rows() * eff_cols();
      repeat (n) send_sample(draw_sample(fill));
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      csr_bus.valid <= 1'b0;
      if (idx == CSR_FRAME_ROWS) rows_reg = value[ROWS_W-1:0];
      else if (idx == CSR_FRAME_COLS) cols_reg = value[COLS_W-1:0];
      @(posedge clock);
   endtask

   // Drop the input, wait for every frame result, then let the pipeline empty.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (pending_counts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic check_counts(input logic [COUNT_W-1:0] got_max,
                               input logic [COUNT_W-1:0] got_min);
      rsp_type want;
      if (pending_counts.size() == 0) begin
         report_mismatch($sformatf("result max=%0d min=%0d with no frame pending",
                                   got_max, got_min));
      end else begin
         want = pending_counts.pop_front();
         if (got_max !== want.max_count)
            report_mismatch($sformatf("frame %0d max_count got %0d expected %0d",
                                      frames_checked, got_max, want.max_count));
         if (got_min !== want.min_count)
            report_mismatch($sformatf("frame %0d min_count got %0d expected %0d",
                                      frames_checked, got_min, want.min_count));
         maxima_total += want.max_count;
         minima_total += want.min_count;
      end
      frames_checked++;
   endtask

   // Result side: random ready gaps, plus a long hold when one is requested.
   initial begin : result_sink
      int gap;
      rsp_bus.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         gap = (sink_hold_cycles > 0) ? sink_hold_cycles : draw_gap(sink_mode);
         sink_hold_cycles = 0;
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         check_counts(rsp_bus.max_count, rsp_bus.min_count);
      end
   end

   task automatic test_reset_defaults();
      // One row by one column after reset: every sample closes a frame.
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      settle();
   endtask

   task automatic test_single_extrema();
      int i;
      write_reg(CSR_FRAME_ROWS, 16'd3);
      write_reg(CSR_FRAME_COLS, 16'd3);
      for (i = 0; i < 9; i++) send_sample((i == 4) ? SAMPLE_MAX : SAMPLE_MIN);
      for (i = 0; i < 9; i++) send_sample((i == 4) ? SAMPLE_MIN : SAMPLE_MAX);
      settle();
   endtask

   task automatic test_register_decode();
      // Zero sizes act as one; bits above the field width are dropped.
      write_reg(CSR_FRAME_ROWS, 16'hF000);
      write_reg(CSR_FRAME_COLS, 16'hF800);
      send_sample(draw_sample(FILL_WIDE));
      settle();
      write_reg(CSR_FRAME_ROWS, 16'hF002);
      write_reg(CSR_FRAME_COLS, 16'hF802);
      write_reg(CSR_UNUSED_IDX, 16'hFFFF);
      write_reg(CSR_SPARE_IDX, 16'h0005);
      send_frame(FILL_EXTREME);
      settle();
   endtask

   task automatic test_size_limits();
      source_mode = IDLE_SPARSE;
      sink_mode   = IDLE_SPARSE;
      // Tall single-column frame, then one wider than the random frames reach.
      write_reg(CSR_FRAME_ROWS, 16'd40);
      write_reg(CSR_FRAME_COLS, 16'd1);
      send_frame(FILL_WIDE);
      settle();
      write_reg(CSR_FRAME_ROWS, 16'd3);
      write_reg(CSR_FRAME_COLS, 16'd60);
      send_frame(FILL_NARROW);
      settle();
   endtask

   task automatic test_input_stall();
      source_mode = IDLE_NONE;
      sink_mode   = IDLE_NONE;
      write_reg(CSR_FRAME_ROWS, 16'd1);
      write_reg(CSR_FRAME_COLS, 16'd1);
      sink_hold_cycles = STALL_CYCLES;
      repeat (48) send_sample(draw_sample(FILL_WIDE));
      settle();
   endtask

   task automatic test_random_frames();
      int unsigned                 start;
      int unsigned                 rows_pick;
      int unsigned                 cols_pick;
      int unsigned                 runs;
      logic [CSR_DATA_W-1:0]       data;
      logic [CSR_IDX_W-1:0]        idx;
      start = samples_sent;
      while (samples_sent - start < RANDOM_SAMPLES) begin
         settle();
         source_mode = idle_mode_type'($urandom_range(0, 2));
         sink_mode   = idle_mode_type'($urandom_range(0, 2));
         rows_pick = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 8);
         cols_pick = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 12);
         if ($urandom_range(0, 15) == 0) rows_pick = $urandom_range(9, 20);
         if ($urandom_range(0, 15) == 0) cols_pick = $urandom_range(13, 40);
         if ($urandom_range(0, 5) != 0) begin
            data = 16'($urandom);
            data[ROWS_W-1:0] = ROWS_W'(rows_pick);
            write_reg(CSR_FRAME_ROWS, data);
         end
         if ($urandom_range(0, 5) != 0) begin
            data = 16'($urandom);
            data[COLS_W-1:0] = COLS_W'(cols_pick);
            write_reg(CSR_FRAME_COLS, data);
         end
         if ($urandom_range(0, 7) == 0) begin
            idx = CSR_IDX_W'($urandom_range(CSR_FRAME_COLS + 1, 255));
            write_reg(idx, 16'($urandom));
         end
         // One to three frames back to back on the same sizes.
         runs = $urandom_range(1, 3);
         repeat (runs) begin
            if (samples_sent - start < RANDOM_SAMPLES)
               send_frame(fill_type'($urandom_range(0, 2)));
         end
      end
      settle();
   endtask

   initial begin : stimulus
      int k;
      reset          <= 1'b1;
      req_bus.valid  <= 1'b0;
      req_bus.sample <= '0;
      csr_bus.valid  <= 1'b0;
      csr_bus.index  <= '0;
      csr_bus.data   <= '0;
      for (k = 0; k < 9; k++) win[k] = '0;
      for (k = 0; k < MAX_COLS; k++) begin
         row_older[k] = '0;
         row_newer[k] = '0;
      end
      col_at      = 0;
      row_at      = 0;
      maxima_seen = '0;
      minima_seen = '0;
      rows_reg    = ROWS_W'(1);
      cols_reg    = COLS_W'(1);
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_single_extrema();
      test_register_decode();
      test_size_limits();
      test_input_stall();
      test_random_frames();

      $display("Summary: %0d samples over %0d frames, %0d maxima and %0d minima counted.",
               samples_sent, frames_checked, maxima_total, minima_total);
      $display("Summary: sizes from 1x1 up to 40 rows and 60 columns, %0d-cycle %s",
               STALL_CYCLES, "result hold with the input stalled.");
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("Timeout: %0d frames pending", pending_counts.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
